// File: hdl/cade_pkg.sv
package cade_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int FRAC_W     = 16;
    localparam int LEN_W      = 24;
    localparam int EXP_W      = 24;
    localparam int STEP_W     = 4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PEAK       = 3'd0,
        REG_ATTACK     = 3'd1,
        REG_DECAY      = 3'd2,
        REG_ATTACK_EXP = 3'd3,
        REG_DECAY_EXP  = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV,
        CMD_NORM,
        CMD_SQR,
        CMD_MUL_LO,
        CMD_MUL_HI,
        CMD_EXP,
        CMD_POW,
        CMD_SCALE
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [STEP_W-1:0] step;
    } t_ctrl;

    typedef struct packed {
        logic skip;
        logic pow_special;
    } t_stat;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        for (int i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // c_k ~ 2^(-2^-k) in Q30, by repeated square roots from 0.5
    function automatic logic [29:0] root_const(input int k);
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int j = 1; j <= k; j++) begin
            c = isqrt(c << 30);
        end
        return c[29:0];
    endfunction

endpackage

// File: hdl/cade_dp.sv
module cade_dp #(
    parameter int VALUE_BITS  = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cade_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [cade_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    input  cade_pkg::t_ctrl                  i_ctrl,
    output cade_pkg::t_stat                  o_stat,
    output logic [VALUE_BITS-1:0]            o_level
);
    import cade_pkg::*;

    localparam int CW = (SAMPLE_BITS > 25) ? SAMPLE_BITS : 25;

    localparam logic [29:0] C_ROOT [16] = '{
        root_const(1),  root_const(2),  root_const(3),  root_const(4),
        root_const(5),  root_const(6),  root_const(7),  root_const(8),
        root_const(9),  root_const(10), root_const(11), root_const(12),
        root_const(13), root_const(14), root_const(15), root_const(16)
    };

    logic [VALUE_BITS-1:0] r_peak;
    logic [LEN_W-1:0]      r_att, r_dec;
    logic [EXP_W-1:0]      r_aexp, r_dexp;

    logic [VALUE_BITS-1:0] r_level;
    logic                  r_skip;
    logic                  r_att_ph;
    logic [EXP_W-1:0]      r_exp;
    logic [LEN_W-1:0]      r_rem, r_den;
    logic [FRAC_W-1:0]     r_quo;
    logic [3:0]            r_p;
    logic [30:0]           r_x;
    logic [FRAC_W-1:0]     r_frac;
    logic [20:0]           r_l;
    logic [44:0]           r_prod;
    logic [30:0]           r_acc;
    logic [16:0]           r_pow;

    // load
    logic [CW-1:0]    idx_ext, end_ext, diff;
    logic             att_ph, past_end;
    assign idx_ext  = CW'(i_sample[SAMPLE_BITS-2:0]);
    assign end_ext  = CW'(25'({1'b0, r_att}) + 25'({1'b0, r_dec}));
    assign att_ph   = idx_ext < CW'(r_att);
    assign past_end = idx_ext >= end_ext;
    assign diff     = idx_ext - CW'(r_att);

    // division step
    logic [24:0] rem_sh;
    logic        ge;
    logic [24:0] rem_sub;
    assign rem_sh  = {r_rem, 1'b0};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    // normalise
    logic [16:0] base;
    logic [3:0]  msb;
    assign base = r_att_ph ? (17'h10000 - {1'b0, r_quo}) : {1'b0, r_quo};
    always_comb begin
        msb = '0;
        for (int i = 0; i < 16; i++) begin
            if (base[i]) msb = 4'(i);
        end
    end

    // squaring step
    logic [61:0] sq;
    logic [31:0] sq_s;
    assign sq   = 62'(r_x) * 62'(r_x);
    assign sq_s = sq[61:30];

    // log times exponent, split into low and high exponent halves
    logic [20:0] l_val;
    logic [32:0] mul_part;
    assign l_val    = {5'(5'd16 - {1'b0, r_p}), 16'b0} - 21'(r_frac);
    always_comb begin
        if (i_ctrl.cmd == CMD_MUL_LO) begin
            mul_part = 33'(l_val) * 33'(r_exp[11:0]);
        end else begin
            mul_part = 33'(r_l) * 33'(r_exp[23:12]);
        end
    end

    logic [12:0] ip;
    logic [15:0] fp;
    assign ip = r_prod[44:32];
    assign fp = r_prod[31:16];

    logic [60:0] ex;
    assign ex = 61'(r_acc) * 61'(C_ROOT[i_ctrl.step]);

    logic [5:0]  sh;
    logic [30:0] acc_sh;
    assign sh     = 6'd14 + {1'b0, ip[4:0]};
    assign acc_sh = r_acc >> sh;

    logic [VALUE_BITS+16:0] lvl_prod;
    logic [VALUE_BITS:0]    lvl;
    assign lvl_prod = (VALUE_BITS+17)'(r_peak) * (VALUE_BITS+17)'(17'h10000 - r_pow);
    assign lvl      = lvl_prod[VALUE_BITS+16:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= VALUE_BITS'(65535);
            r_att   <= '0;
            r_dec   <= '0;
            r_aexp  <= EXP_W'(65536);
            r_dexp  <= EXP_W'(65536);
            r_level <= '0;
            r_skip  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_PEAK:       r_peak <= i_cfg_data[VALUE_BITS-1:0];
                    REG_ATTACK:     r_att  <= i_cfg_data[LEN_W-1:0];
                    REG_DECAY:      r_dec  <= i_cfg_data[LEN_W-1:0];
                    REG_ATTACK_EXP: r_aexp <= i_cfg_data[EXP_W-1:0];
                    REG_DECAY_EXP:  r_dexp <= i_cfg_data[EXP_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctrl.cmd == CMD_LOAD) begin
                // negative index keeps the last level
                r_skip <= i_sample[SAMPLE_BITS-1] | past_end;
                if (!i_sample[SAMPLE_BITS-1] && past_end) r_level <= '0;
            end
            if (i_ctrl.cmd == CMD_SCALE) begin
                r_level <= lvl[VALUE_BITS] ? '1 : lvl[VALUE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            CMD_LOAD: begin
                r_att_ph <= att_ph;
                r_exp    <= att_ph ? r_aexp : r_dexp;
                r_rem    <= att_ph ? idx_ext[LEN_W-1:0] : diff[LEN_W-1:0];
                r_den    <= att_ph ? r_att : r_dec;
                r_quo    <= '0;
            end
            CMD_DIV: begin
                r_rem <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
                r_quo <= {r_quo[FRAC_W-2:0], ge};
            end
            CMD_NORM: begin
                r_p    <= msb;
                r_x    <= 31'(base[15:0]) << (5'd30 - {1'b0, msb});
                r_frac <= '0;
                if (r_att_ph || r_exp == '0) r_pow <= 17'h10000;
                else r_pow <= '0;
            end
            CMD_SQR: begin
                r_frac <= {r_frac[FRAC_W-2:0], sq_s[31]};
                r_x    <= sq_s[31] ? sq_s[31:1] : sq_s[30:0];
            end
            CMD_MUL_LO: begin
                r_l    <= l_val;
                r_prod <= 45'(mul_part);
            end
            CMD_MUL_HI: begin
                r_prod <= r_prod + (45'(mul_part) << 12);
                r_acc  <= 31'h4000_0000;
            end
            CMD_EXP: begin
                if (fp[4'd15 - i_ctrl.step]) r_acc <= ex[60:30];
            end
            CMD_POW: begin
                r_pow <= (ip >= 13'd17) ? '0 : acc_sh[16:0];
            end
            default: ;
        endcase
    end

    assign o_stat.skip        = r_skip;
    assign o_stat.pow_special = (r_quo == '0);
    assign o_level            = r_level;

endmodule

// File: hdl/cade_ctrl.sv
module cade_ctrl #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_BITS-1:0] o_out_data,
    output cade_pkg::t_ctrl       o_ctrl,
    input  cade_pkg::t_stat       i_stat,
    input  logic [VALUE_BITS-1:0] i_level
);
    import cade_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_DIV, S_NORM, S_SQR, S_MUL_LO, S_MUL_HI,
        S_EXP, S_POW, S_SCALE, S_FIN
    } t_state;

    t_state                r_state, n_state;
    logic [STEP_W-1:0]     r_step, n_step;
    logic                  r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0] r_out_data, n_out_data;
    logic                  last;

    assign last       = (r_step == '1);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_ctrl.step = r_step;
        case (r_state)
            S_IDLE:   o_ctrl.cmd = i_in_valid ? CMD_LOAD : CMD_NONE;
            S_DIV:    o_ctrl.cmd = CMD_DIV;
            S_NORM:   o_ctrl.cmd = CMD_NORM;
            S_SQR:    o_ctrl.cmd = CMD_SQR;
            S_MUL_LO: o_ctrl.cmd = CMD_MUL_LO;
            S_MUL_HI: o_ctrl.cmd = CMD_MUL_HI;
            S_EXP:    o_ctrl.cmd = CMD_EXP;
            S_POW:    o_ctrl.cmd = CMD_POW;
            S_SCALE:  o_ctrl.cmd = CMD_SCALE;
            default:  o_ctrl.cmd = CMD_NONE;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_CLASS;
            S_CLASS: begin
                n_step  = '0;
                n_state = i_stat.skip ? S_FIN : S_DIV;
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (last) n_state = S_NORM;
            end
            S_NORM:   n_state = i_stat.pow_special ? S_SCALE : S_SQR;
            S_SQR: begin
                n_step = r_step + 1'b1;
                if (last) n_state = S_MUL_LO;
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_EXP;
            S_EXP: begin
                n_step = r_step + 1'b1;
                if (last) n_state = S_POW;
            end
            S_POW:    n_state = S_SCALE;
            S_SCALE:  n_state = S_FIN;
            S_FIN: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = i_level;
                    n_state     = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while busy");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_state == S_FIN))
        else $error("result loaded outside finish");

    a_sqr_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |=> (r_state == S_SQR) == !$past(i_stat.pow_special))
        else $error("log path taken for special base");

    a_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM || r_state == S_MUL_HI) |-> r_step == '0)
        else $error("step counter not wrapped");

endmodule

// File: hdl/curved_attack_decay_envelope_core.sv
// Curved attack/decay envelope core.
// Input stream s_axis: one signed sample index per request; output stream
// m_axis: the envelope level for that index, one result per request, in order.
// Config channel: write peak, attack/decay lengths and Q8.16 exponents by
// index 0..4 while the core is idle; other indices are ignored.
// A new index is taken once the previous one has moved to the output
// register. Per index the 16-step restoring divider, 16 log squarings and
// 16 exp multiplies run in sequence; the squarings and multiplies are
// skipped when the base is 0 or 1, and all three for a negative or
// past-the-end index.
// A stalled output register holds its result; the core can take the next
// index meanwhile and waits at the end of that computation.
// Reset (synchronous, active low) restores the register defaults and clears
// the held level to zero; a negative index returns the held level.
module curved_attack_decay_envelope_core #(
    parameter int VALUE_BITS  = 16,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // [SB-1:0] sample_index
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((VALUE_BITS+7)/8)*8-1:0]      m_axis_tdata,  // [VB-1:0] env_value
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cade_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [cade_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cade_pkg::*;

    localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

    t_ctrl                 ctrl;
    t_stat                 stat;
    logic [VALUE_BITS-1:0] level;
    logic [VALUE_BITS-1:0] out_data;

    assign o_cfg_ready = 1'b1;

    cade_dp #(
        .VALUE_BITS  (VALUE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_sample   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .o_level    (level)
    );

    cade_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (out_data),
        .o_ctrl      (ctrl),
        .i_stat      (stat),
        .i_level     (level)
    );

    assign m_axis_tdata = OUT_W'(out_data);

endmodule

// File: verif/cade_env_checker.sv
module cade_env_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import cade_pkg::*;

    logic [15:0] peak;
    logic [23:0] att_len;
    logic [23:0] dec_len;
    logic [23:0] att_exp;
    logic [23:0] dec_exp;
    logic [15:0] last_level;
    logic [63:0] half_roots [0:16];
    logic [15:0] level_q [$];

    function automatic logic [63:0] sqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = v;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // b^e with b in Q16 [0,1], e in Q8.16, via -log2 then exp2
    function automatic logic [63:0] pow_q16(input logic [63:0] b, input logic [63:0] e);
        logic [63:0] x;
        logic [63:0] frac;
        logic [63:0] nlog;
        logic [63:0] y;
        logic [63:0] ip;
        logic [63:0] fp;
        logic [63:0] r;
        int          msb;
        frac = '0;
        msb  = 0;
        if (b == 0) return (e == 0) ? 64'd65536 : 64'd0;
        if (b >= 64'd65536) return 64'd65536;
        while ((b >> (msb + 1)) != 0) msb++;
        x = b << (30 - msb);
        for (int k = 0; k < 16; k++) begin
            x    = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd1 << 31)) begin
                x    = x >> 1;
                frac = frac | 64'd1;
            end
        end
        nlog = (64'(16 - msb) << 16) - frac;
        y    = (nlog * e) >> 16;
        ip   = y >> 16;
        fp   = y & 64'hFFFF;
        if (ip >= 17) return 64'd0;
        r = 64'd1 << 30;
        for (int k = 1; k <= 16; k++) begin
            if ((fp >> (16 - k)) & 64'd1) r = (r * half_roots[k]) >> 30;
        end
        return r >> (14 + ip);
    endfunction

    function automatic logic [15:0] scaled(input logic [63:0] pw);
        logic [63:0] v;
        v = (64'(peak) * (64'd65536 - pw)) >> 16;
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] envelope_level(input logic [31:0] idx);
        logic [63:0] pos;
        logic [63:0] t;
        pos = 64'(idx);
        if (pos >= 64'(att_len) + 64'(dec_len)) return 16'd0;
        if (pos >= 64'(att_len)) begin
            t = ((pos - 64'(att_len)) << 16) / 64'(dec_len);
            return scaled(pow_q16(t, 64'(dec_exp)));
        end
        t = (pos << 16) / 64'(att_len);
        return scaled(pow_q16(64'd65536 - t, 64'(att_exp)));
    endfunction

    initial begin
        half_roots[0] = 64'd1 << 29;
        for (int k = 1; k <= 16; k++) half_roots[k] = sqrt64(half_roots[k-1] << 30);
    end

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            peak       <= 16'hFFFF;
            att_len    <= '0;
            dec_len    <= '0;
            att_exp    <= 24'd65536;
            dec_exp    <= 24'd65536;
            last_level <= '0;
            level_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (level_q.size() == 0) begin
                    $error("env_value: no request outstanding, actual %0d", m_axis_tdata);
                    o_errors++;
                end else begin
                    want = level_q.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("env_value: expected %0d actual %0d", want, m_axis_tdata);
                        o_errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                // negative index repeats the held level
                if (s_axis_tdata[31]) begin
                    level_q.push_back(last_level);
                end else begin
                    want = envelope_level(s_axis_tdata);
                    last_level <= want;
                    level_q.push_back(want);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    REG_PEAK:       peak    <= i_cfg_data[15:0];
                    REG_ATTACK:     att_len <= i_cfg_data[23:0];
                    REG_DECAY:      dec_len <= i_cfg_data[23:0];
                    REG_ATTACK_EXP: att_exp <= i_cfg_data[23:0];
                    REG_DECAY_EXP:  dec_exp <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
        end
        o_pending <= level_q.size();
    end
endmodule

// File: verif/curved_attack_decay_envelope_core_tb.sv
module curved_attack_decay_envelope_core_tb;
    import cade_pkg::*;

    localparam logic [2:0] REG_UNUSED_LO = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;
    localparam int         PHASES        = 13;
    localparam int         PHASE_ITEMS   = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;

    int errors;
    int pending;
    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int indices_sent = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int unsigned env_end;

    always #1 i_clk = ~i_clk;

    curved_attack_decay_envelope_core i_dut (.*);

    cade_env_checker i_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_addr, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    // receiver: random back-pressure plus one long hold-off mid-run
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && indices_sent >= 500) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 400;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    task automatic send_index(input logic [31:0] idx);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= idx;
        do @(posedge i_clk); while (!s_axis_tready);
        indices_sent++;
    endtask

    // leaves valid high so that writes can follow back to back
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_len();
        case ($urandom_range(7))
            0:       return 24'd0;
            1:       return 24'd1;
            2:       return 24'hFFFFFF;
            3:       return 24'($urandom);
            default: return 24'($urandom_range(1, 3000));
        endcase
    endfunction

    function automatic logic [23:0] pick_exp();
        case ($urandom_range(7))
            0:       return 24'd0;
            1:       return 24'd65536;
            2:       return 24'hFFFFFF;
            3:       return 24'($urandom);
            default: return 24'($urandom_range(1, 8 * 65536));
        endcase
    endfunction

    // upper bits of the write data are random; the core must ignore them
    task automatic program_regs(input logic [15:0] pk, input logic [23:0] al,
                                input logic [23:0] dl, input logic [23:0] ae,
                                input logic [23:0] de);
        write_reg(REG_PEAK, {16'($urandom_range(65535)), 16'h0} | 32'(pk));
        write_reg(REG_ATTACK, {8'($urandom), al});
        write_reg(REG_DECAY, {8'($urandom), dl});
        write_reg(REG_ATTACK_EXP, {8'($urandom), ae});
        write_reg(REG_DECAY_EXP, {8'($urandom), de});
        i_cfg_valid <= 1'b0;
        env_end = 32'(al) + 32'(dl);
    endtask

    function automatic logic [31:0] pick_index();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return {1'b1, 31'($urandom)};
        if (r < 20) return $urandom;
        if (env_end > 32'h7FFF_FFF0) return 32'($urandom_range(0, 32'h7FFF_FFFF));
        return $urandom_range(0, env_end + 4);
    endfunction

    initial begin
        logic [15:0] pk;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: zero lengths, so every non-negative index is past the end
        send_index(32'd0);
        send_index(32'd5);
        send_index(32'hFFFF_FFFF);
        drain();
        write_reg(REG_UNUSED_LO, 32'h1234);
        write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
        program_regs(16'hFFFF, 24'd100, 24'd200, 24'd65536, 24'd65536);
        send_index(32'd0);
        send_index(32'd1);
        send_index(32'd50);
        send_index(32'h8000_0000);
        send_index(32'd99);
        send_index(32'd100);
        send_index(32'd101);
        send_index(32'd299);
        send_index(32'd300);
        send_index(32'h7FFF_FFFF);
        send_index(32'hFFFF_FFFF);
        drain();
        // zero exponents and zero attack
        program_regs(16'd40000, 24'd0, 24'd64, 24'd0, 24'd0);
        send_index(32'd0);
        send_index(32'd10);
        send_index(32'd63);
        drain();
        program_regs(16'd0, 24'd7, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_index(32'd3);
        send_index(32'd1000);
        send_index(32'h00FF_FFFF);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph * 3 / PHASES)
                0: begin send_gap_pct = 19; recv_gap_pct = 53; end
                1: begin send_gap_pct = 53; recv_gap_pct = 19; end
                default: begin send_gap_pct = 0; recv_gap_pct = 0; end
            endcase
            case ($urandom_range(3))
                0:       pk = 16'd0;
                1:       pk = 16'hFFFF;
                default: pk = 16'($urandom);
            endcase
            program_regs(pk, pick_len(), pick_len(), pick_exp(), pick_exp());
            for (int n = 0; n < PHASE_ITEMS; n++) send_index(pick_index());
            drain();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: filelist.f
hdl/cade_pkg.sv
hdl/cade_dp.sv
hdl/cade_ctrl.sv
hdl/curved_attack_decay_envelope_core.sv
verif/cade_env_checker.sv
verif/curved_attack_decay_envelope_core_tb.sv
